@@ hdl/yenc_stream_decoder_defines.svh @@
// Assertion macros for the yEnc stream decoder.
// No dependencies; included by the top level.
`ifndef YENC_STREAM_DECODER_DEFINES_SVH
`define YENC_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define YSD_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("yenc_stream_decoder: check failed");
// next-cycle implication, sampled on clk, off during reset
`define YSD_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("yenc_stream_decoder: check failed");
`else
`define YSD_ASSERT_IMP(lbl, a, b)
`define YSD_ASSERT_NXT(lbl, a, b)
`endif

`endif

@@ hdl/yenc_pkg.sv @@
// Shared types, character constants and keyword tables for the yEnc decoder.
// No dependencies.
package yenc_pkg;

    // special characters
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_EQ = 8'h3D;

    localparam logic [7:0] PLAIN_OFFSET  = 8'd42;
    localparam logic [7:0] ESCAPE_OFFSET = 8'd64;

    localparam logic [3:0] POS_MAX   = 4'd15;
    localparam logic [3:0] LEN_BEGIN = 4'd8;
    localparam logic [3:0] LEN_PART  = 4'd7;
    localparam logic [3:0] LEN_END   = 4'd5;

    // match_alive bit positions
    localparam int unsigned ALIVE_BEGIN = 0;
    localparam int unsigned ALIVE_PART  = 1;
    localparam int unsigned ALIVE_END   = 2;
    localparam logic [2:0]  ALIVE_MSG   = 3'b011;
    localparam logic [2:0]  ALIVE_BODY  = 3'b100;

    // result event codes
    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_BEGIN = 2'd1,
        EV_PART  = 2'd2,
        EV_END   = 2'd3
    } event_t;

    // keyword completed on the current byte
    typedef enum logic [1:0] {
        HIT_NONE  = 2'd0,
        HIT_BEGIN = 2'd1,
        HIT_PART  = 2'd2,
        HIT_END   = 2'd3
    } kw_hit_t;

    // decoder state carried from item to item
    typedef struct packed {
        logic       in_body;
        logic       escape_pending;
        logic [3:0] line_position;
        logic       keyword_line;
        logic [2:0] match_alive;
    } yenc_state_t;

    // keyword matcher result
    typedef struct packed {
        logic [2:0] next_alive;
        kw_hit_t    hit;
    } kw_match_t;

    // "=ybegin "
    function automatic logic [7:0] kw_begin_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3D;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h62;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h67;
            3'd5:    c = 8'h69;
            3'd6:    c = 8'h6E;
            3'd7:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "=ypart "
    function automatic logic [7:0] kw_part_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3D;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h70;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h74;
            3'd6:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "=yend"
    function automatic logic [7:0] kw_end_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3D;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/yenc_kw_match.sv @@
// Line-start keyword matcher: advances the three keyword trackers by one byte.
// Depends on yenc_pkg.
module yenc_kw_match (
    input  logic [3:0]          pos,
    input  logic [7:0]          byte_in,
    input  logic [2:0]          alive,
    output yenc_pkg::kw_match_t result
);
    import yenc_pkg::*;

    logic ok_begin;
    logic ok_part;
    logic ok_end;

    // per-keyword compare at this line position
    assign ok_begin = alive[ALIVE_BEGIN] && (pos < LEN_BEGIN)
                      && (byte_in == kw_begin_char(pos[2:0]));
    assign ok_part  = alive[ALIVE_PART] && (pos < LEN_PART)
                      && (byte_in == kw_part_char(pos[2:0]));
    assign ok_end   = alive[ALIVE_END] && (pos < LEN_END)
                      && (byte_in == kw_end_char(pos[2:0]));

    // survivors and completed keyword; footer takes priority
    always_comb
    begin
        result.next_alive = {ok_end, ok_part, ok_begin};
        result.hit        = HIT_NONE;
        if (ok_begin && (pos == LEN_BEGIN - 4'd1))
        begin
            result.hit = HIT_BEGIN;
        end
        if (ok_part && (pos == LEN_PART - 4'd1))
        begin
            result.hit = HIT_PART;
        end
        if (ok_end && (pos == LEN_END - 4'd1))
        begin
            result.hit = HIT_END;
        end
    end

endmodule

@@ hdl/yenc_dec_step.sv @@
// One-byte decode step: next decoder state and the optional result item.
// Depends on yenc_pkg and yenc_kw_match.
module yenc_dec_step (
    input  yenc_pkg::yenc_state_t st,
    input  logic [7:0]            byte_in,
    output yenc_pkg::yenc_state_t st_next,
    output logic                  emit,
    output logic [7:0]            out_value,
    output yenc_pkg::event_t      out_event
);
    import yenc_pkg::*;

    logic [2:0] alive_eff;
    logic       kwl_eff;
    kw_match_t  match;

    // a new line restarts the trackers for the current mode
    always_comb
    begin
        alive_eff = st.match_alive;
        kwl_eff   = st.keyword_line;
        if (st.line_position == 4'd0)
        begin
            alive_eff = st.in_body ? ALIVE_BODY : ALIVE_MSG;
            kwl_eff   = 1'b0;
        end
    end

    yenc_kw_match u_match (
        .pos     (st.line_position),
        .byte_in (byte_in),
        .alive   (alive_eff),
        .result  (match)
    );

    // state update and result
    always_comb
    begin
        st_next   = st;
        emit      = 1'b0;
        out_value = 8'd0;
        out_event = EV_DATA;
        if (byte_in == CH_LF)
        begin
            st_next.line_position  = 4'd0;
            st_next.keyword_line   = 1'b0;
            st_next.match_alive    = 3'd0;
            st_next.escape_pending = 1'b0;
        end
        else
        begin
            if (st.line_position < POS_MAX)
            begin
                st_next.line_position = st.line_position + 4'd1;
            end
            st_next.keyword_line = kwl_eff;
            st_next.match_alive  = (match.hit != HIT_NONE) ? 3'd0 : match.next_alive;
            if (!st.in_body)
            begin
                // message text: only a header line does anything
                if (match.hit == HIT_BEGIN || match.hit == HIT_PART)
                begin
                    st_next.in_body        = 1'b1;
                    st_next.keyword_line   = 1'b1;
                    st_next.escape_pending = 1'b0;
                    emit                   = 1'b1;
                    out_event              = (match.hit == HIT_BEGIN) ? EV_BEGIN : EV_PART;
                end
            end
            else if (match.hit == HIT_END)
            begin
                st_next.in_body        = 1'b0;
                st_next.keyword_line   = 1'b1;
                st_next.escape_pending = 1'b0;
                emit                   = 1'b1;
                out_event              = EV_END;
            end
            else if (kwl_eff)
            begin
                // rest of a keyword line is dropped
            end
            else if ((st.line_position == 4'd1) && match.next_alive[ALIVE_END])
            begin
                // body line starting "=y" is a keyword line
                st_next.keyword_line   = 1'b1;
                st_next.escape_pending = 1'b0;
            end
            else if (byte_in == CH_CR)
            begin
                // dropped, escape stays armed
            end
            else if (st.escape_pending)
            begin
                st_next.escape_pending = 1'b0;
                emit                   = 1'b1;
                out_value              = byte_in - PLAIN_OFFSET - ESCAPE_OFFSET;
            end
            else if (byte_in == CH_EQ)
            begin
                st_next.escape_pending = 1'b1;
            end
            else
            begin
                emit      = 1'b1;
                out_value = byte_in - PLAIN_OFFSET;
            end
        end
    end

endmodule

@@ hdl/yenc_stream_decoder.sv @@
// yEnc stream decoder: one raw byte per item, zero or one result per item.
// Each accepted byte is registered in s1, decoded, and its result registered in the result register.
// Throughput: 1 item per cycle; input stalls only while a held result blocks the result register.
// Reset (rst_n, async active low) clears both register valids and the decoder
// state: message mode, no escape, at line start, no keyword tracking.
// Depends on yenc_pkg, yenc_dec_step and yenc_stream_decoder_defines.svh.
`include "yenc_stream_decoder_defines.svh"

module yenc_stream_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            raw_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic [1:0]            event_res
);
    import yenc_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    event_t      out_event_reg;
    yenc_state_t state_reg;
    yenc_state_t state_next;
    yenc_state_t step_state;
    logic        step_emit;
    logic [7:0]  step_value;
    event_t      step_event;
    logic        advance;
    logic        consume;

    // result register free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign consume  = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    yenc_dec_step u_step (
        .st        (state_reg),
        .byte_in   (s1_byte_reg),
        .st_next   (step_state),
        .emit      (step_emit),
        .out_value (step_value),
        .out_event (step_event)
    );

    // next values for control registers
    always_comb
    begin
        s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
        out_valid_next = advance ? (s1_valid_reg && step_emit) : out_valid_reg;
        state_next     = consume ? step_state : state_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= raw_byte;
        end
        if (consume && step_emit)
        begin
            out_byte_reg  <= step_value;
            out_event_reg <= step_event;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign event_res = out_event_reg;

    // checks
    `YSD_ASSERT_IMP(a_esc_only_in_body, state_reg.escape_pending, state_reg.in_body)
    `YSD_ASSERT_NXT(a_header_enters_body,
        consume && step_emit && (step_event == EV_BEGIN || step_event == EV_PART),
        state_reg.in_body)
    `YSD_ASSERT_IMP(a_event_byte_zero,
        out_valid_reg && (out_event_reg != EV_DATA), out_byte_reg == 8'd0)

endmodule
